[src/assert_macros.svh]
// Assertion macros for the RTL of the matrix column transform, used by its top level.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MCT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[src/mct_pkg.sv]
// Package for the matrix column transform: word widths, beat and result types.
// No dependencies; imported by every module of the block.
`default_nettype none

package mct_pkg;

    // Fixed point format and port widths
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int IO_W      = 32;
    localparam int LANES     = 4;
    localparam int PROD_W    = 2 * WORD_BITS;
    localparam int ACC_W     = PROD_W + 2;

    // One in Q format, clamped to the largest positive word
    localparam longint unsigned ONE_RAW = 64'd1 << FRAC_BITS;
    localparam longint unsigned MAX_POS = (64'd1 << (WORD_BITS - 1)) - 64'd1;
    localparam longint unsigned ONE_VAL = (ONE_RAW > MAX_POS) ? MAX_POS : ONE_RAW;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [ACC_W-1:0]     t_acc;
    typedef logic [IO_W-1:0]      t_io;

    localparam t_word ONE = t_word'(ONE_VAL);

    // Item mode codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_XFRM = 1'b1;

    // Beat that travels down the chain of cells
    typedef struct packed {
        logic                  vld;
        logic                  load;
        logic [1:0]            col;
        logic [1:0]            row;
        t_word                 coeff;
        t_word [LANES-1:0]     x;
        t_acc  [LANES-1:0]     acc;
    } t_beat;

    // Finished result beat
    typedef struct packed {
        t_io [LANES-1:0] y;
        logic            ovf;
    } t_res;

endpackage

`default_nettype wire

[src/mct_cell.sv]
// One column cell: holds one column of the matrix, multiplies it by its
// element of the incoming vector and adds into the running sums. Uses mct_pkg.
`default_nettype none

module mct_cell import mct_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_adv,
    input  wire logic [1:0] i_col,
    input  wire t_beat i_beat,
    output t_beat      o_beat
);

    // Full width signed product of two words
    function automatic logic signed [PROD_W-1:0] mul_w(input t_word a, input t_word b);
        logic signed [PROD_W-1:0] ea;
        logic signed [PROD_W-1:0] eb;
        ea = PROD_W'($signed(a));
        eb = PROD_W'($signed(b));
        return ea * eb;
    endfunction

    t_word                     r_coef [LANES];
    t_beat                     r_sa;
    t_beat                     r_sb;
    t_beat                     n_sb;
    logic signed [PROD_W-1:0]  r_prod [LANES];
    t_word                     w_xj;

    assign w_xj = i_beat.x[i_col];

    // Hold this column; reset to identity, write when a load beat for it passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < LANES; r++) begin
                r_coef[r] <= (2'(r) == i_col) ? ONE : '0;
            end
        end else if (i_adv && i_beat.vld && i_beat.load && (i_beat.col == i_col)) begin
            r_coef[i_beat.row] <= i_beat.coeff;
        end
    end

    // Stage A: register products and forward the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa.vld <= 1'b0;
        end else if (i_adv) begin
            r_sa <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int r = 0; r < LANES; r++) begin
                r_prod[r] <= mul_w(r_coef[r], w_xj);
            end
        end
    end

    // Stage B: add products into the running sums
    always_comb begin
        n_sb = r_sa;
        for (int r = 0; r < LANES; r++) begin
            n_sb.acc[r] = r_sa.acc[r] + ACC_W'(r_prod[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb.vld <= 1'b0;
        end else if (i_adv) begin
            r_sb <= n_sb;
        end
    end

    assign o_beat = r_sb;

endmodule

`default_nettype wire

[src/mct_sat.sv]
// Result stage: shifts each sum down by the fraction bits, saturates it to a
// word and sign-extends it to the port width. Uses mct_pkg.
`default_nettype none

module mct_sat import mct_pkg::*; (
    input  wire t_beat i_beat,
    output t_res       o_res
);

    localparam t_word W_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam t_word W_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    logic signed [ACC_W-1:0]     w_sh   [LANES];
    logic [ACC_W-WORD_BITS:0]    w_top  [LANES];
    logic [LANES-1:0]            w_sat;
    t_word                       w_y    [LANES];

    // Floor shift, range check on the upper bits, clamp
    always_comb begin
        for (int r = 0; r < LANES; r++) begin
            w_sh[r]  = $signed(i_beat.acc[r]) >>> FRAC_BITS;
            w_top[r] = w_sh[r][ACC_W-1:WORD_BITS-1];
            w_sat[r] = !((&w_top[r]) || !(|w_top[r]));
            if (w_sat[r]) begin
                w_y[r] = w_sh[r][ACC_W-1] ? W_MIN : W_MAX;
            end else begin
                w_y[r] = w_sh[r][WORD_BITS-1:0];
            end
            o_res.y[r] = IO_W'($signed(w_y[r]));
        end
        o_res.ovf = |w_sat;
    end

endmodule

`default_nettype wire

[src/mct_outq.sv]
// Two-entry result queue that decouples the cell chain from the output
// handshake; its full flag stalls the chain. Uses mct_pkg.
`default_nettype none

module mct_outq import mct_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_res i_data,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_data
);

    t_res       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[src/matrix_column_transform_4x4_unit.sv]
// Top level of the 4x4 matrix column transform: chain of four column cells,
// result stage and output queue. Uses mct_pkg, mct_cell, mct_sat, mct_outq.
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+-------------------------------------------
//   input   | i_valid | o_ready | i_mode, i_index, i_coeff, i_x0 .. i_x3
//   output  | o_valid | i_ready | o_y0 .. o_y3, o_overflow
//
// One beat enters per cycle, loads and transforms alike, while the two-entry
// output queue is not full. A transform result passes eight register stages
// (multiply and add in each of four cells) and is then written into the queue
// from the last stage and offered on the output channel.
// A load writes its cell when it passes it, so it acts on every later transform
// and on none before it. Reset loads identity. A full queue stalls the chain.
`default_nettype none
`include "assert_macros.svh"

module matrix_column_transform_4x4_unit import mct_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_mode,
    input  wire logic [3:0]  i_index,
    input  wire logic [31:0] i_coeff,
    input  wire logic [31:0] i_x0,
    input  wire logic [31:0] i_x1,
    input  wire logic [31:0] i_x2,
    input  wire logic [31:0] i_x3,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_y0,
    output logic [31:0]      o_y1,
    output logic [31:0]      o_y2,
    output logic [31:0]      o_y3,
    output logic             o_overflow
);

    t_beat w_chain [LANES+1];
    t_res  w_res;
    t_res  w_qout;
    logic  w_full;
    logic  w_adv;
    logic  w_push;

    // Advance the chain whenever the queue has room
    assign w_adv   = !w_full;
    assign o_ready = w_adv;

    // Build the entry beat
    always_comb begin
        w_chain[0].vld   = i_valid;
        w_chain[0].load  = (i_mode == MODE_LOAD);
        w_chain[0].col   = i_index[3:2];
        w_chain[0].row   = i_index[1:0];
        w_chain[0].coeff = t_word'(i_coeff);
        w_chain[0].x[0]  = t_word'(i_x0);
        w_chain[0].x[1]  = t_word'(i_x1);
        w_chain[0].x[2]  = t_word'(i_x2);
        w_chain[0].x[3]  = t_word'(i_x3);
        for (int r = 0; r < LANES; r++) begin
            w_chain[0].acc[r] = '0;
        end
    end

    // Row of column cells
    for (genvar g = 0; g < LANES; g++) begin : g_cell
        mct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_col   (2'(g)),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g+1])
        );
    end

    mct_sat u_sat (
        .i_beat (w_chain[LANES]),
        .o_res  (w_res)
    );

    // Push transform results only; drop load beats at the end of the chain
    assign w_push = w_adv && w_chain[LANES].vld && !w_chain[LANES].load;

    mct_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_qout)
    );

    assign o_y0       = w_qout.y[0];
    assign o_y1       = w_qout.y[1];
    assign o_y2       = w_qout.y[2];
    assign o_y3       = w_qout.y[3];
    assign o_overflow = w_qout.ovf;

    `MCT_ASSERT_ALWAYS(a_rst_no_out, $past(!i_rst_n) |-> !o_valid, "result shown right after reset")
    `MCT_ASSERT(a_push_shows, $past(w_push) |-> o_valid, "pushed result not offered")
    `MCT_ASSERT(a_stall_holds, w_full |=> $stable(w_chain[LANES]), "chain moved while queue full")

endmodule

`default_nettype wire

[tb/sv/matrix_column_transform_4x4_unit_test.sv]
// Self-checking testbench for matrix_column_transform_4x4_unit: coefficient loads and
// column transforms, checked against a Q16.16 matrix predictor kept in the bench.
// Depends on mct_pkg and the RTL of the block only.
`default_nettype none

module matrix_column_transform_4x4_unit_test import mct_pkg::*; ();

    localparam int ACC_BITS       = 2 * WORD_BITS + 2;
    localparam int RANDOM_BEATS   = 1500;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF       = 400;

    typedef logic signed [ACC_BITS-1:0] t_wide;

    localparam t_wide WORD_MAX = (t_wide'(1) <<< (WORD_BITS - 1)) - t_wide'(1);
    localparam t_wide WORD_MIN = -(t_wide'(1) <<< (WORD_BITS - 1));
    localparam t_wide ONE_RAW_Q = t_wide'(1) <<< FRAC_BITS;
    localparam t_wide ONE_Q     = (ONE_RAW_Q > WORD_MAX) ? WORD_MAX : ONE_RAW_Q;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_NEG = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0][31:0] y;
        logic             ovf;
    } t_column_result;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } t_rx_style;

    // Block ports
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_ready;
    logic        i_mode     = MODE_LOAD;
    logic [3:0]  i_index    = '0;
    logic [31:0] i_coeff    = '0;
    logic [31:0] i_x0       = '0;
    logic [31:0] i_x1       = '0;
    logic [31:0] i_x2       = '0;
    logic [31:0] i_x3       = '0;
    logic        o_valid;
    logic        i_ready    = 1'b0;
    logic [31:0] o_y0;
    logic [31:0] o_y1;
    logic [31:0] o_y2;
    logic [31:0] o_y3;
    logic        o_overflow;

    // Predictor state and bench bookkeeping
    logic [31:0]    coef_store [16];
    t_column_result pending_columns [$];
    int             error_count   = 0;
    int             beats_sent    = 0;
    int             burst_left    = 0;
    bit             gaps_on       = 1'b1;
    t_rx_style      rx_style      = RX_ALWAYS;
    int             hold_request  = 0;
    int             hold_left     = 0;
    int             rx_cycle      = 0;
    int             stall_cycles  = 0;

    matrix_column_transform_4x4_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_index    (i_index),
        .i_coeff    (i_coeff),
        .i_x0       (i_x0),
        .i_x1       (i_x1),
        .i_x2       (i_x2),
        .i_x3       (i_x3),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_y0       (o_y0),
        .o_y1       (o_y1),
        .o_y2       (o_y2),
        .o_y3       (o_y3),
        .o_overflow (o_overflow)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Sign-extend the low WORD_BITS bits of a port word to accumulator width
    function automatic t_wide word_value(logic [31:0] raw);
        logic signed [31:0] s;
        s = $signed(raw << (32 - WORD_BITS)) >>> (32 - WORD_BITS);
        return t_wide'(s);
    endfunction

    // y[i] = sum over j of A[4j+i] * x[j], floored shift, saturated to a word
    function automatic t_column_result transform_column(logic [3:0][31:0] x);
        t_column_result r;
        t_wide          sum;
        t_wide          scaled;
        r.ovf = 1'b0;
        for (int i = 0; i < 4; i++) begin
            sum = '0;
            for (int j = 0; j < 4; j++)
                sum = sum + word_value(coef_store[4 * j + i]) * word_value(x[j]);
            scaled = sum >>> FRAC_BITS;
            if (scaled > WORD_MAX) begin
                scaled = WORD_MAX;
                r.ovf  = 1'b1;
            end else if (scaled < WORD_MIN) begin
                scaled = WORD_MIN;
                r.ovf  = 1'b1;
            end
            r.y[i] = scaled[31:0];
        end
        return r;
    endfunction

    // Mix of extremes, small Q16.16 values and raw random words
    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return $urandom_range(0, 1) ? Q_NEG : 32'h1;
            4, 5: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0][31:0] rand_column();
        logic [3:0][31:0] x;
        for (int j = 0; j < 4; j++)
            x[j] = rand_q();
        return x;
    endfunction

    // Track accepted input beats: loads update the store, transforms queue a result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++)
                coef_store[k] = (k % 5 == 0) ? ONE_Q[31:0] : 32'h0;
        end else if (i_valid && o_ready) begin
            if (i_mode == MODE_LOAD)
                coef_store[i_index] = i_coeff;
            else
                pending_columns.push_back(transform_column({i_x3, i_x2, i_x1, i_x0}));
        end
    end

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endtask

    // Compare each result beat with the oldest pending column
    always @(posedge i_clk) begin
        t_column_result   want;
        logic [3:0][31:0] got;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_y3, o_y2, o_y1, o_y0};
            if (pending_columns.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result beat, expected none, got %h ovf %b",
                         $time, got, o_overflow);
            end else begin
                want = pending_columns.pop_front();
                for (int i = 0; i < 4; i++)
                    if (got[i] !== want.y[i])
                        report_mismatch($sformatf("y%0d", i), want.y[i], got[i]);
                if (o_overflow !== want.ovf)
                    report_mismatch("overflow", 32'(want.ovf), 32'(o_overflow));
            end
        end
    end

    // Receiver: long hold-off on request, otherwise stall by the selected style
    always @(posedge i_clk) begin
        rx_cycle++;
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            case (rx_style)
                RX_ALWAYS:  i_ready <= 1'b1;
                RX_RANDOM:  i_ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: i_ready <= ((rx_cycle % 7) < 4);
                default:    i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one beat, hold it until taken, then idle if the burst is over
    task automatic send_beat(logic mode, logic [3:0] idx, logic [31:0] c,
                             logic [3:0][31:0] x);
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_index <= idx;
        i_coeff <= c;
        i_x0    <= x[0];
        i_x1    <= x[1];
        i_x2    <= x[2];
        i_x3    <= x[3];
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        beats_sent++;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Load one coefficient; the column fields carry noise
    task automatic load_coef(logic [3:0] idx, logic [31:0] c);
        send_beat(MODE_LOAD, idx, c, {$urandom, $urandom, $urandom, $urandom});
    endtask

    // Transform one column; index and coefficient carry noise
    task automatic send_column(logic [3:0][31:0] x);
        send_beat(MODE_XFRM, 4'($urandom), $urandom, x);
    endtask

    // Stop offering, let the last taken beat reach the predictor, then wait
    // for every pending column to come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_columns.size() != 0)
            @(posedge i_clk);
    endtask

    // Identity after reset passes the extreme words through unchanged
    task automatic test_identity_extremes();
        rx_style = RX_ALWAYS;
        gaps_on  = 1'b0;
        send_column({Q_NEG, 32'h0, Q_MIN, Q_MAX});
        send_column({Q_MAX, Q_MIN, 32'hFFFF_0000, 32'h1});
        wait_drained();
    endtask

    // Saturate high and low through one extreme coefficient, then restore it
    task automatic test_saturation();
        rx_style = RX_RANDOM;
        gaps_on  = 1'b1;
        load_coef(4'd0, Q_MAX);
        send_column({32'h0, 32'h0, 32'h0, Q_MAX});
        load_coef(4'd0, Q_MIN);
        send_column({32'h0, 32'h0, 32'h0, Q_MIN});
        send_column({32'h0, 32'h0, 32'h0, Q_MAX});
        load_coef(4'd0, ONE_Q[31:0]);
        wait_drained();
    endtask

    // Shift floors toward minus infinity; a load acts on the very next column
    task automatic test_floor_shift();
        rx_style = RX_PATTERN;
        gaps_on  = 1'b0;
        load_coef(4'd5, 32'h1);
        send_column({32'h0, 32'h0, Q_NEG, 32'h0});
        send_column({32'h0, 32'h0, 32'h0000_FFFF, 32'h0});
        load_coef(4'd5, ONE_Q[31:0]);
        wait_drained();
    endtask

    // Hold the output off while columns keep coming, so the input stalls
    task automatic test_backpressure();
        rx_style     = RX_ALWAYS;
        gaps_on      = 1'b0;
        hold_request = HOLD_OFF;
        repeat (40)
            send_column(rand_column());
        wait_drained();
    endtask

    // Mostly well-formed products: reload part or all of A, then four columns
    task automatic test_random_products();
        int sel;
        int loads;
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            gaps_on  = ($urandom_range(0, 4) != 0);
            sel      = $urandom_range(0, 9);
            if (sel <= 5) begin
                if ($urandom_range(0, 3) == 0) begin
                    for (int k = 0; k < 16; k++)
                        load_coef(4'(k), rand_q());
                end else begin
                    loads = $urandom_range(1, 6);
                    repeat (loads)
                        load_coef(4'($urandom), rand_q());
                end
                repeat (4)
                    send_column(rand_column());
            end else if (sel <= 8) begin
                send_beat($urandom_range(0, 1) ? MODE_XFRM : MODE_LOAD, 4'($urandom),
                          rand_q(), rand_column());
            end else begin
                repeat ($urandom_range(1, 12))
                    send_column(rand_column());
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (8)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_identity_extremes();
        test_saturation();
        test_floor_shift();
        test_backpressure();
        test_random_products();
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);
        if (pending_columns.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, pending_columns.size());
        end
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/mct_pkg.sv
src/mct_cell.sv
src/mct_sat.sv
src/mct_outq.sv
src/matrix_column_transform_4x4_unit.sv
tb/sv/matrix_column_transform_4x4_unit_test.sv
